/* rtl/core/lsfc_pkg.sv */
// Shared types and constants for the signature-keyed format cache.
// No dependencies; imported by every module of the block.
`default_nettype none
package lsfc_pkg;

  localparam int SLOTS_DEFAULT       = 24;
  localparam int MAX_FMT_LEN_DEFAULT = 64;
  localparam int WORDS_PER_SLOT      = 8;
  localparam int WORD_IDX_W          = 3;
  localparam int SIG_W               = 16;
  localparam int LEN_W               = 7;
  localparam int AGE_W               = 32;
  localparam int WORD_W              = 64;

  typedef enum logic [1:0] {
    OP_REMEMBER = 2'd0,
    OP_LOOKUP   = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef struct packed {
    logic               clear_all;
    logic               set_all;
    logic               set_age;
    logic [SIG_W-1:0]   sig;
    logic [LEN_W-1:0]   len;
    logic [AGE_W-1:0]   age;
  } slot_wr_t;

endpackage
`default_nettype wire

/* rtl/core/lru_signature_format_cache_top.sv */
// Top level of the signature-keyed LRU format cache: sequencer, use clock,
// pending write, output register. Depends on lsfc_pkg and all lsfc_ modules.
//
//   channel | valid     | stall     | payload
//   req     | req_valid | req_stall | opcode signature length word_index format_word
//   rsp     | rsp_valid | rsp_stall | hit found_length out_word_index out_format_word last
//
// Remember word 0 (valid length) and lookup scan one slot a cycle through the
// shared compare unit, then end in S_FIN. A lookup hit then reads the format
// memory a word at a time, held by rsp stalls. Other items never leave idle.
// Reset clears the slot table at once; the format memory has no clearing pass.
// req_stall is high while an item is in progress; rsp stalls hold the output.
`default_nettype none
module lru_signature_format_cache_top
  import lsfc_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEFAULT,
  parameter int MAX_FMT_LEN = MAX_FMT_LEN_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire logic [1:0]            opcode,
  input  wire logic [SIG_W-1:0]      signature,
  input  wire logic [7:0]            length,
  input  wire logic [WORD_IDX_W-1:0] word_index,
  input  wire logic [WORD_W-1:0]     format_word,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output logic                       hit,
  output logic [LEN_W-1:0]           found_length,
  output logic [WORD_IDX_W-1:0]      out_word_index,
  output logic [WORD_W-1:0]          out_format_word,
  output logic                       last
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ADDR_W = SLOT_W + WORD_IDX_W;
  localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FIN  = 5'b00100,
    S_READ = 5'b01000,
    S_SEND = 5'b10000
  } state_t;

  state_t state, state_next;

  logic                  is_lookup;
  logic [SIG_W-1:0]      key;
  logic [LEN_W-1:0]      len_q;
  logic [WORD_W-1:0]     word_q;
  logic [SLOT_W-1:0]     scan_idx;
  logic [AGE_W-1:0]      use_clock;
  logic [SLOT_W-1:0]     pending_slot;
  logic                  pending_write;
  logic [LEN_W-1:0]      pending_len;
  logic [SLOT_W-1:0]     sel_slot;
  logic [LEN_W-1:0]      sel_len;
  logic [WORD_IDX_W-1:0] word_k;
  logic [WORD_IDX_W-1:0] last_k;
  logic                  hit_q;

  logic                  accept;
  opcode_t               op;
  logic                  len_ok;
  logic                  word_in_len;
  logic                  out_load;

  slot_wr_t              twr;
  logic [SLOT_W-1:0]     twr_idx;
  logic [SLOT_W-1:0]     rd_idx;
  logic [SIG_W-1:0]      rd_sig;
  logic [LEN_W-1:0]      rd_len;
  logic [AGE_W-1:0]      rd_age;
  logic                  found;
  logic [SLOT_W-1:0]     found_idx;
  logic [SLOT_W-1:0]     min_idx;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;
  logic [LEN_W-1:0]      bytes_left;
  logic [WORD_W-1:0]     masked_word;
  logic [LEN_W-1:0]      rd_len_m1;

  assign req_stall   = (state != S_IDLE);
  assign accept      = req_valid && !req_stall;
  assign op          = opcode_t'(opcode);
  assign len_ok      = (length != 8'd0) && (length <= 8'(MAX_FMT_LEN));
  assign word_in_len = {1'b0, word_index, 3'b000} < pending_len;
  assign out_load    = (state == S_SEND) && (!rsp_valid || !rsp_stall);
  assign rd_idx      = (state == S_SCAN) ? scan_idx : found_idx;
  assign rd_len_m1   = rd_len - LEN_W'(1);

  lsfc_slot_table #(.SLOTS(SLOTS), .SLOT_W(SLOT_W)) u_table (
    .clk    (clk),
    .rst    (rst),
    .wr     (twr),
    .wr_idx (twr_idx),
    .rd_idx (rd_idx),
    .rd_sig (rd_sig),
    .rd_len (rd_len),
    .rd_age (rd_age)
  );

  lsfc_scan_unit #(.SLOTS(SLOTS), .SLOT_W(SLOT_W)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (state == S_SCAN),
    .idx       (scan_idx),
    .key       (key),
    .slot_sig  (rd_sig),
    .slot_len  (rd_len),
    .slot_age  (rd_age),
    .found     (found),
    .found_idx (found_idx),
    .min_idx   (min_idx)
  );

  lsfc_format_ram #(.SLOTS(SLOTS), .SLOT_W(SLOT_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_READ),
    .raddr ({sel_slot, word_k}),
    .rdata (ram_rdata)
  );

  always_comb begin
    twr           = '0;
    twr.sig       = key;
    twr.len       = len_q;
    twr.age       = use_clock + AGE_W'(1);
    twr_idx       = found ? found_idx : min_idx;
    ram_we        = 1'b0;
    ram_waddr     = {pending_slot, word_index};
    ram_wdata     = format_word;
    if (accept && (op == OP_CLEAR)) begin
      twr.clear_all = 1'b1;
    end
    if (accept && (op == OP_REMEMBER) && (word_index != '0) && pending_write &&
        word_in_len) begin
      ram_we = 1'b1;
    end
    if (state == S_FIN) begin
      if (found) begin
        twr.set_age = 1'b1;
      end else if (!is_lookup) begin
        twr.set_all = 1'b1;
        twr.set_age = 1'b1;
        ram_we      = 1'b1;
        ram_waddr   = {min_idx, WORD_IDX_W'(0)};
        ram_wdata   = word_q;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_LOOKUP || (op == OP_REMEMBER && word_index == '0 && len_ok)) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx == SCAN_LAST) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!is_lookup) begin
          state_next = S_IDLE;
        end else if (found) begin
          state_next = S_READ;
        end else begin
          state_next = S_SEND;
        end
      end
      S_READ: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_load) begin
          state_next = (!hit_q || word_k == last_k) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      scan_idx      <= '0;
      use_clock     <= '0;
      pending_slot  <= '0;
      pending_write <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (op == OP_CLEAR)) begin
        pending_write <= 1'b0;
      end
      if (accept && (op == OP_REMEMBER) && (word_index == '0)) begin
        pending_write <= 1'b0;
      end
      if (state == S_SCAN) begin
        scan_idx <= (scan_idx == SCAN_LAST) ? '0 : scan_idx + SLOT_W'(1);
      end
      if (state == S_FIN && (found || !is_lookup)) begin
        use_clock <= use_clock + AGE_W'(1);
      end
      if (state == S_FIN && !found && !is_lookup) begin
        pending_slot  <= min_idx;
        pending_write <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_lookup <= (op == OP_LOOKUP);
      key       <= signature;
      len_q     <= length[LEN_W-1:0];
      word_q    <= format_word;
    end
    if (state == S_FIN) begin
      if (!is_lookup && !found) begin
        pending_len <= len_q;
      end
      hit_q    <= found;
      sel_slot <= found_idx;
      sel_len  <= rd_len;
      last_k   <= rd_len_m1[LEN_W-2:3];
      word_k   <= '0;
    end
    if (out_load && hit_q && word_k != last_k) begin
      word_k <= word_k + WORD_IDX_W'(1);
    end
  end

  assign bytes_left = sel_len - {1'b0, word_k, 3'b000};

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      masked_word[b*8 +: 8] = (LEN_W'(b) < bytes_left) ? ram_rdata[b*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit             <= hit_q;
      found_length    <= hit_q ? sel_len : '0;
      out_word_index  <= hit_q ? word_k : '0;
      out_format_word <= hit_q ? masked_word : '0;
      last            <= !hit_q || (word_k == last_k);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lsfc_slot_table.sv */
// Slot tag table: signature, length and age per slot, in flip-flops.
// Depends on lsfc_pkg (slot_wr_t, field widths).
`default_nettype none
module lsfc_slot_table
  import lsfc_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEFAULT,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire slot_wr_t          wr,
  input  wire logic [SLOT_W-1:0] wr_idx,
  input  wire logic [SLOT_W-1:0] rd_idx,
  output logic [SIG_W-1:0]       rd_sig,
  output logic [LEN_W-1:0]       rd_len,
  output logic [AGE_W-1:0]       rd_age
);

  logic [SIG_W-1:0] sig_arr [SLOTS];
  logic [LEN_W-1:0] len_arr [SLOTS];
  logic [AGE_W-1:0] age_arr [SLOTS];

  always_ff @(posedge clk) begin
    if (rst || wr.clear_all) begin
      for (int i = 0; i < SLOTS; i++) begin
        sig_arr[i] <= '0;
        len_arr[i] <= '0;
        age_arr[i] <= '0;
      end
    end else begin
      if (wr.set_all) begin
        sig_arr[wr_idx] <= wr.sig;
        len_arr[wr_idx] <= wr.len;
      end
      if (wr.set_age) begin
        age_arr[wr_idx] <= wr.age;
      end
    end
  end

  assign rd_sig = sig_arr[rd_idx];
  assign rd_len = len_arr[rd_idx];
  assign rd_age = age_arr[rd_idx];

endmodule
`default_nettype wire

/* rtl/core/lsfc_scan_unit.sv */
// Shared compare unit: one slot per step, tracks first signature match
// and first oldest slot. Depends on lsfc_pkg.
`default_nettype none
module lsfc_scan_unit
  import lsfc_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEFAULT,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [SLOT_W-1:0] idx,
  input  wire logic [SIG_W-1:0]  key,
  input  wire logic [SIG_W-1:0]  slot_sig,
  input  wire logic [LEN_W-1:0]  slot_len,
  input  wire logic [AGE_W-1:0]  slot_age,
  output logic                   found,
  output logic [SLOT_W-1:0]      found_idx,
  output logic [SLOT_W-1:0]      min_idx
);

  logic [AGE_W-1:0] min_age;
  logic             first;
  logic             match;
  logic             older;

  assign first = (idx == '0);
  assign match = (slot_len != '0) && (slot_sig == key);
  assign older = slot_age < min_age;

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (step) begin
      if (first) begin
        found <= match;
      end else if (match) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (first || (match && !found)) begin
        found_idx <= idx;
      end
      if (first || older) begin
        min_age <= slot_age;
        min_idx <= idx;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lsfc_format_ram.sv */
// Format word memory, eight words per slot, one write and one
// registered read port. Depends on lsfc_pkg.
`default_nettype none
module lsfc_format_ram
  import lsfc_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEFAULT,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [SLOT_W+WORD_IDX_W-1:0] waddr,
  input  wire logic [WORD_W-1:0]            wdata,
  input  wire logic                         re,
  input  wire logic [SLOT_W+WORD_IDX_W-1:0] raddr,
  output logic [WORD_W-1:0]                 rdata
);

  localparam int DEPTH = SLOTS * WORDS_PER_SLOT;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
